[src/llca_pkg.sv]
package llca_pkg;

  // fixed field widths
  localparam int CORE_W = 4;
  localparam int DEV_W  = 6;
  localparam int MASK_W = 16;
  localparam int LOAD_W = 16;
  localparam int CNT_W  = 8;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // command codes
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

[src/llca_ram.sv]
module llca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/least_loaded_core_assigner_core.sv]
// least-loaded core assigner: places device queues on worker cores
// acquire: a one-core-per-cycle scan of the stores picks the core; a new transaction is
//   accepted only after the previous result has been loaded into the result register
// release: read, then write back; a new transaction is accepted only after its result is loaded
// rst_n is synchronous, active low; after reset a clearing pass over all NUM_DEVICES * NUM_CORES
//   addresses zeroes both stores, in_ready stays low meanwhile (cfg writes still taken)
module least_loaded_core_assigner_core #(
  parameter int NUM_CORES   = 16,
  parameter int NUM_DEVICES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [llca_pkg::MASK_W-1:0]  cfg_wdata,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [llca_pkg::DEV_W-1:0]   in_device_id,
  input  logic [llca_pkg::CORE_W-1:0]  in_core_index,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [llca_pkg::CORE_W-1:0]  out_chosen_core
);

  localparam int CW    = $clog2(NUM_CORES);
  localparam int DEPTH = NUM_DEVICES * NUM_CORES;
  localparam int DAW   = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_REL,
    ST_FIN
  } state_t;

  // control and item registers
  state_t                          state_r, state_nxt;
  logic [DAW-1:0]                  clr_r, clr_nxt;
  logic [llca_pkg::MASK_W-1:0]     mask_r, mask_nxt;
  logic                            cmd_r, cmd_nxt;
  logic [llca_pkg::CORE_W-1:0]     core_r, core_nxt;
  logic [DAW-1:0]                  base_r, base_nxt;
  logic [CW-1:0]                   cur_r, cur_nxt;
  logic                            en_load_r, en_load_nxt;
  logic                            en_cnt_r, en_cnt_nxt;

  // best candidate among cores without the device
  logic                            ffound_r, ffound_nxt;
  logic [llca_pkg::LOAD_W-1:0]     fload_r, fload_nxt;
  logic [CW-1:0]                   fidx_r, fidx_nxt;

  // best candidate among all running cores (also holds the release target)
  logic                            afound_r, afound_nxt;
  logic [llca_pkg::LOAD_W-1:0]     aload_r, aload_nxt;
  logic [CW-1:0]                   aidx_r, aidx_nxt;
  logic [llca_pkg::CNT_W-1:0]      acnt_r, acnt_nxt;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_status_r, out_status_nxt;
  logic [llca_pkg::CORE_W-1:0]     out_core_r, out_core_nxt;

  // memory ports
  logic                            load_we, cnt_we;
  logic [CW-1:0]                   load_waddr, load_raddr;
  logic [DAW-1:0]                  cnt_waddr, cnt_raddr;
  logic [llca_pkg::LOAD_W-1:0]     load_wdata, load_rdata;
  logic [llca_pkg::CNT_W-1:0]      cnt_wdata, cnt_rdata;

  // helpers
  logic                            accept;
  logic                            in_dev_ok, in_core_ok;
  logic [DAW-1:0]                  in_base;
  logic [CW-1:0]                   rd_idx;
  logic [llca_pkg::CORE_W-1:0]     cur_narrow;
  logic                            cur_running;
  logic                            found;
  logic [CW-1:0]                   pick;
  logic [llca_pkg::LOAD_W-1:0]     pick_load, new_load;
  logic [llca_pkg::CNT_W-1:0]      pick_cnt, new_cnt;
  logic                            fin_go;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign in_dev_ok  = 32'(in_device_id) < NUM_DEVICES;
  assign in_core_ok = 32'(in_core_index) < NUM_CORES;
  assign in_base    = DAW'(32'(in_device_id) * NUM_CORES);

  // read side: first entry is issued while accepting, the scan runs one core ahead
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_idx = (in_cmd == llca_pkg::CMD_RELEASE) ? CW'(in_core_index) : '0;
    end else begin
      rd_idx = CW'(cur_r + 1'b1);
    end
  end

  assign load_raddr = rd_idx;
  assign cnt_raddr  = ((state_r == ST_IDLE) ? in_base : base_r) + DAW'(rd_idx);

  // running test for the core whose data is arriving; only 16 cores have a mask bit
  assign cur_narrow  = llca_pkg::CORE_W'(cur_r);
  assign cur_running = (32'(cur_r) < llca_pkg::MASK_W) && mask_r[cur_narrow];

  // final choice: a core free of the device wins, else the least-loaded running core
  assign found     = ffound_r || afound_r;
  assign pick      = ffound_r ? fidx_r : aidx_r;
  assign pick_load = ffound_r ? fload_r : aload_r;
  assign pick_cnt  = ffound_r ? '0 : acnt_r;

  // saturating increment on acquire, floor at zero on release
  always_comb begin
    if (cmd_r == llca_pkg::CMD_ACQUIRE) begin
      new_load = (pick_load == llca_pkg::LOAD_MAX) ? pick_load : pick_load + 1'b1;
      new_cnt  = (pick_cnt == llca_pkg::CNT_MAX) ? pick_cnt : pick_cnt + 1'b1;
    end else begin
      new_load = (pick_load == '0) ? pick_load : pick_load - 1'b1;
      new_cnt  = (pick_cnt == '0) ? pick_cnt : pick_cnt - 1'b1;
    end
  end

  // write-back happens together with loading the result register
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign load_we    = (state_r == ST_CLEAR) || (fin_go && en_load_r && found);
  assign load_waddr = (state_r == ST_CLEAR) ? clr_r[CW-1:0] : pick;
  assign load_wdata = (state_r == ST_CLEAR) ? '0 : new_load;

  assign cnt_we     = (state_r == ST_CLEAR) || (fin_go && en_cnt_r && found);
  assign cnt_waddr  = (state_r == ST_CLEAR) ? clr_r : base_r + DAW'(pick);
  assign cnt_wdata  = (state_r == ST_CLEAR) ? '0 : new_cnt;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    mask_nxt       = cfg_we ? cfg_wdata : mask_r;
    cmd_nxt        = cmd_r;
    core_nxt       = core_r;
    base_nxt       = base_r;
    cur_nxt        = cur_r;
    en_load_nxt    = en_load_r;
    en_cnt_nxt     = en_cnt_r;
    ffound_nxt     = ffound_r;
    fload_nxt      = fload_r;
    fidx_nxt       = fidx_r;
    afound_nxt     = afound_r;
    aload_nxt      = aload_r;
    aidx_nxt       = aidx_r;
    acnt_nxt       = acnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_core_nxt   = out_core_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == DAW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          core_nxt   = in_core_index;
          base_nxt   = in_base;
          cur_nxt    = '0;
          ffound_nxt = 1'b0;
          afound_nxt = 1'b0;
          if (in_cmd == llca_pkg::CMD_ACQUIRE) begin
            en_load_nxt = in_dev_ok;
            en_cnt_nxt  = in_dev_ok;
            // out-of-range device fails straight away
            state_nxt   = in_dev_ok ? ST_SCAN : ST_FIN;
          end else begin
            en_load_nxt = in_core_ok;
            en_cnt_nxt  = in_core_ok && in_dev_ok;
            afound_nxt  = 1'b1;
            aidx_nxt    = CW'(in_core_index);
            state_nxt   = ST_REL;
          end
        end
      end

      ST_SCAN: begin
        // strict less-than keeps ties on the lowest index
        if (cur_running && cnt_rdata == '0 && (!ffound_r || load_rdata < fload_r)) begin
          ffound_nxt = 1'b1;
          fload_nxt  = load_rdata;
          fidx_nxt   = cur_r;
        end
        if (cur_running && (!afound_r || load_rdata < aload_r)) begin
          afound_nxt = 1'b1;
          aload_nxt  = load_rdata;
          aidx_nxt   = cur_r;
          acnt_nxt   = cnt_rdata;
        end
        cur_nxt = CW'(cur_r + 1'b1);
        if (cur_r == CW'(NUM_CORES - 1)) begin
          state_nxt = ST_FIN;
        end
      end

      ST_REL: begin
        aload_nxt = load_rdata;
        acnt_nxt  = cnt_rdata;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          if (cmd_r == llca_pkg::CMD_ACQUIRE) begin
            out_status_nxt = found ? llca_pkg::STATUS_OK : llca_pkg::STATUS_FAIL;
            out_core_nxt   = found ? llca_pkg::CORE_W'(pick) : '0;
          end else begin
            out_status_nxt = llca_pkg::STATUS_OK;
            out_core_nxt   = core_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    core_r       <= core_nxt;
    base_r       <= base_nxt;
    cur_r        <= cur_nxt;
    en_load_r    <= en_load_nxt;
    en_cnt_r     <= en_cnt_nxt;
    ffound_r     <= ffound_nxt;
    fload_r      <= fload_nxt;
    fidx_r       <= fidx_nxt;
    afound_r     <= afound_nxt;
    aload_r      <= aload_nxt;
    aidx_r       <= aidx_nxt;
    acnt_r       <= acnt_nxt;
    out_status_r <= out_status_nxt;
    out_core_r   <= out_core_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chosen_core = out_core_r;

  // per-core load
  llca_ram #(
    .WIDTH (llca_pkg::LOAD_W),
    .DEPTH (NUM_CORES)
  ) u_load_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_waddr),
    .wdata (load_wdata),
    .raddr (load_raddr),
    .rdata (load_rdata)
  );

  // per-device, per-core queue count, one row of NUM_CORES entries per device
  llca_ram #(
    .WIDTH (llca_pkg::CNT_W),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

`ifndef SYNTHESIS
  // an accepted transaction always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted transaction did not start work");

  // a failed acquire leaves both stores untouched
  a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && cmd_r == llca_pkg::CMD_ACQUIRE && !found) |-> (!load_we && !cnt_we))
    else $error("failed acquire wrote a store");

  // a new result only follows the write-back state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_FIN))
    else $error("result appeared outside write-back");

  // a successful acquire picks a running core
  a_pick_running: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && cmd_r == llca_pkg::CMD_ACQUIRE && found) |->
      (32'(pick) < llca_pkg::MASK_W && mask_r[llca_pkg::CORE_W'(pick)]))
    else $error("acquire picked a core that is not running");
`endif

endmodule
